[rtl/pftr_pkg.sv]
// Shared types and constants for the page frame translate and replace block.
package pftr_pkg;

    localparam int OFFSET_WIDTH    = 8;
    localparam int ADDRESS_WIDTH   = 16;
    localparam int PAGE_WIDTH      = ADDRESS_WIDTH - OFFSET_WIDTH;
    localparam int FRAME_COUNT_DEF = 4;
    localparam int COUNT_WIDTH     = 32;
    localparam int FRAME_OUT_WIDTH = 2;
    localparam int PHYS_WIDTH      = FRAME_OUT_WIDTH + OFFSET_WIDTH;
    localparam int APB_ADDR_WIDTH  = 3;
    localparam int APB_DATA_WIDTH  = 32;

    // register index, taken from byte address bit 2
    localparam logic REG_POLICY_MODE = 1'b0;

    typedef enum logic {
        POLICY_FIFO = 1'b0,
        POLICY_LRU  = 1'b1
    } t_policy;

    typedef struct packed {
        logic                        was_hit;
        logic [FRAME_OUT_WIDTH-1:0]  frame_used;
        logic                        eviction_done;
        logic [PAGE_WIDTH-1:0]       evicted_page;
    } t_xlate_res;

endpackage

[rtl/pftr_cfg.sv]
// APB configuration register holding the replacement policy.
module pftr_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pftr_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [pftr_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [pftr_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                pready,
    output pftr_pkg::t_policy                   o_policy
);

    pftr_pkg::t_policy r_policy;
    logic              w_sel_policy;

    assign w_sel_policy = (paddr[2] == pftr_pkg::REG_POLICY_MODE);
    assign pready       = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= pftr_pkg::POLICY_FIFO;
        end else if (psel && penable && pwrite && pready && w_sel_policy) begin
            r_policy <= pftr_pkg::t_policy'(pwdata[0]);
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_policy) begin
            prdata[0] = r_policy;
        end
    end

    assign o_policy = r_policy;

endmodule

[rtl/pftr_table.sv]
// Frame table: tag match, victim choice and FIFO/LRU state update.
module pftr_table #(
    parameter int FRAME_COUNT = pftr_pkg::FRAME_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  logic [pftr_pkg::PAGE_WIDTH-1:0]   i_page,
    input  pftr_pkg::t_policy                 i_policy,
    output pftr_pkg::t_xlate_res              o_res
);

    localparam int FW = $clog2(FRAME_COUNT);
    localparam logic [FW-1:0] RANK_MAX = FW'(FRAME_COUNT - 1);
    localparam logic [FW-1:0] PTR_LAST = FW'(FRAME_COUNT - 1);

    logic [pftr_pkg::PAGE_WIDTH-1:0] r_tag  [FRAME_COUNT];
    logic [pftr_pkg::PAGE_WIDTH-1:0] n_tag  [FRAME_COUNT];
    logic [FW-1:0]                   r_rank [FRAME_COUNT];
    logic [FW-1:0]                   n_rank [FRAME_COUNT];
    logic [FRAME_COUNT-1:0]          r_valid;
    logic [FRAME_COUNT-1:0]          n_valid;
    logic [FW-1:0]                   r_fifo_ptr;
    logic [FW-1:0]                   n_fifo_ptr;

    logic          w_hit;
    logic [FW-1:0] w_hit_idx;
    logic          w_empty;
    logic [FW-1:0] w_empty_idx;
    logic [FW-1:0] w_lru_idx;
    logic [FW-1:0] w_lru_best;
    logic [FW-1:0] w_frame;
    logic          w_evict;
    logic          w_lru;
    logic [FW-1:0] w_old_rank;

    assign w_lru = (i_policy == pftr_pkg::POLICY_LRU);

    always_comb begin
        w_hit       = 1'b0;
        w_hit_idx   = '0;
        w_empty     = 1'b0;
        w_empty_idx = '0;
        w_lru_idx   = '0;
        w_lru_best  = '0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            if (!w_hit && r_valid[i] && (r_tag[i] == i_page)) begin
                w_hit     = 1'b1;
                w_hit_idx = FW'(i);
            end
            if (!w_empty && !r_valid[i]) begin
                w_empty     = 1'b1;
                w_empty_idx = FW'(i);
            end
            if (r_rank[i] > w_lru_best) begin
                w_lru_best = r_rank[i];
                w_lru_idx  = FW'(i);
            end
        end
    end

    always_comb begin
        w_evict = 1'b0;
        if (w_hit) begin
            w_frame = w_hit_idx;
        end else if (w_empty) begin
            w_frame = w_empty_idx;
        end else begin
            w_evict = 1'b1;
            w_frame = w_lru ? w_lru_idx : r_fifo_ptr;
        end
    end

    assign w_old_rank = r_rank[w_frame];

    always_comb begin
        n_tag      = r_tag;
        n_rank     = r_rank;
        n_valid    = r_valid;
        n_fifo_ptr = r_fifo_ptr;
        if (i_fire) begin
            if (!w_hit) begin
                n_tag[w_frame]   = i_page;
                n_valid[w_frame] = 1'b1;
            end
            if (!w_hit && w_evict && !w_lru) begin
                n_fifo_ptr = (r_fifo_ptr == PTR_LAST) ? '0 : r_fifo_ptr + 1'b1;
            end
            if (w_lru) begin
                for (int g = 0; g < FRAME_COUNT; g++) begin
                    if ((FW'(g) != w_frame) && r_valid[g]
                        && (!w_hit || (r_rank[g] < w_old_rank))
                        && (r_rank[g] != RANK_MAX)) begin
                        n_rank[g] = r_rank[g] + 1'b1;
                    end
                end
                n_rank[w_frame] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_fifo_ptr <= '0;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid    <= n_valid;
            r_fifo_ptr <= n_fifo_ptr;
            r_rank     <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
    end

    always_comb begin
        o_res.was_hit       = w_hit;
        o_res.frame_used    = pftr_pkg::FRAME_OUT_WIDTH'(w_frame);
        o_res.eviction_done = w_evict;
        o_res.evicted_page  = w_evict ? r_tag[w_frame] : '0;
    end

endmodule

[rtl/page_frame_translate_replace.sv]
// Page frame translation with FIFO/LRU replacement, top level.
// Each input is registered, translated by the frame table, and the result registered at the output.
// Throughput: 1 item per cycle while the result side does not stall; set by the frame table lookup and update.
// Stalls on the result side back up through the input register.
// Reset (synchronous, active low) empties all frames, clears ranks, FIFO pointer,
// counters, and sets the policy to FIFO.
module page_frame_translate_replace #(
    parameter int FRAME_COUNT = pftr_pkg::FRAME_COUNT_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [pftr_pkg::ADDRESS_WIDTH-1:0]    i_logical_address,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_was_hit,
    output logic [pftr_pkg::FRAME_OUT_WIDTH-1:0]  o_frame_used,
    output logic [pftr_pkg::PHYS_WIDTH-1:0]       o_physical_address,
    output logic                                  o_eviction_done,
    output logic [pftr_pkg::PAGE_WIDTH-1:0]       o_evicted_page,
    output logic [pftr_pkg::COUNT_WIDTH-1:0]      o_hit_total,
    output logic [pftr_pkg::COUNT_WIDTH-1:0]      o_fault_total,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pftr_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [pftr_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [pftr_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                  pready
);

    localparam logic [pftr_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic                                 r_in_valid;
    logic [pftr_pkg::ADDRESS_WIDTH-1:0]   r_addr;
    logic                                 r_out_valid;
    logic [pftr_pkg::COUNT_WIDTH-1:0]     r_hit_cnt;
    logic [pftr_pkg::COUNT_WIDTH-1:0]     n_hit_cnt;
    logic [pftr_pkg::COUNT_WIDTH-1:0]     r_fault_cnt;
    logic [pftr_pkg::COUNT_WIDTH-1:0]     n_fault_cnt;
    logic                                 r_was_hit;
    logic [pftr_pkg::FRAME_OUT_WIDTH-1:0] r_frame_used;
    logic [pftr_pkg::PHYS_WIDTH-1:0]      r_phys_addr;
    logic                                 r_eviction_done;
    logic [pftr_pkg::PAGE_WIDTH-1:0]      r_evicted_page;
    logic [pftr_pkg::COUNT_WIDTH-1:0]     r_hit_total;
    logic [pftr_pkg::COUNT_WIDTH-1:0]     r_fault_total;
    logic                                 w_advance;
    logic                                 w_fire;
    pftr_pkg::t_policy                    w_policy;
    pftr_pkg::t_xlate_res                 w_res;

    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_fire     = r_in_valid && w_advance;

    pftr_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_policy (w_policy)
    );

    pftr_table #(
        .FRAME_COUNT (FRAME_COUNT)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_page   (r_addr[pftr_pkg::ADDRESS_WIDTH-1:pftr_pkg::OFFSET_WIDTH]),
        .i_policy (w_policy),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_addr <= i_logical_address;
        end
    end

    always_comb begin
        n_hit_cnt   = r_hit_cnt;
        n_fault_cnt = r_fault_cnt;
        if (w_fire) begin
            if (w_res.was_hit) begin
                n_hit_cnt = (r_hit_cnt == COUNT_MAX) ? r_hit_cnt : r_hit_cnt + 1'b1;
            end else begin
                n_fault_cnt = (r_fault_cnt == COUNT_MAX) ? r_fault_cnt
                                                         : r_fault_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hit_cnt   <= '0;
            r_fault_cnt <= '0;
        end else begin
            r_hit_cnt   <= n_hit_cnt;
            r_fault_cnt <= n_fault_cnt;
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_was_hit       <= w_res.was_hit;
            r_frame_used    <= w_res.frame_used;
            r_phys_addr     <= {w_res.frame_used,
                                r_addr[pftr_pkg::OFFSET_WIDTH-1:0]};
            r_eviction_done <= w_res.eviction_done;
            r_evicted_page  <= w_res.evicted_page;
            r_hit_total     <= n_hit_cnt;
            r_fault_total   <= n_fault_cnt;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_was_hit          = r_was_hit;
    assign o_frame_used       = r_frame_used;
    assign o_physical_address = r_phys_addr;
    assign o_eviction_done    = r_eviction_done;
    assign o_evicted_page     = r_evicted_page;
    assign o_hit_total        = r_hit_total;
    assign o_fault_total      = r_fault_total;

endmodule

[rtl/pftr_checker.sv]
// Port-level checker for the page frame translate and replace block, with bind.
module pftr_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic                                  o_was_hit,
    input logic [pftr_pkg::FRAME_OUT_WIDTH-1:0]  o_frame_used,
    input logic [pftr_pkg::PHYS_WIDTH-1:0]       o_physical_address,
    input logic                                  o_eviction_done,
    input logic [pftr_pkg::PAGE_WIDTH-1:0]       o_evicted_page,
    input logic [pftr_pkg::COUNT_WIDTH-1:0]      o_hit_total,
    input logic [pftr_pkg::COUNT_WIDTH-1:0]      o_fault_total
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_physical_address)
            && $stable(o_hit_total) && $stable(o_fault_total))
        else $error("result changed while stalled");

    a_evict_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_eviction_done |-> !o_was_hit)
        else $error("eviction reported on a hit");

    a_no_evict_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_eviction_done |-> o_evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    a_phys_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_physical_address[pftr_pkg::PHYS_WIDTH-1:pftr_pkg::OFFSET_WIDTH]
            == o_frame_used)
        else $error("physical address frame bits differ from frame");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind page_frame_translate_replace pftr_checker u_pftr_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_was_hit          (o_was_hit),
    .o_frame_used       (o_frame_used),
    .o_physical_address (o_physical_address),
    .o_eviction_done    (o_eviction_done),
    .o_evicted_page     (o_evicted_page),
    .o_hit_total        (o_hit_total),
    .o_fault_total      (o_fault_total)
);
